### sv/integer_factor_pixel_rescaler_macros.svh
// assertion macros for the integer factor pixel rescaler
`ifndef INTEGER_FACTOR_PIXEL_RESCALER_MACROS_SVH
`define INTEGER_FACTOR_PIXEL_RESCALER_MACROS_SVH
`ifndef SYNTH
`define IFPR_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ifpr check failed");
`define IFPR_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ifpr check failed");
`else
`define IFPR_ASSERT_IMP(label, clk, rst_n, a, c)
`define IFPR_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### sv/ifpr_pkg.sv
// shared types and constants of the pixel rescaler
package ifpr_pkg;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_FACTOR = 16;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int FAC_W = $clog2(MAX_FACTOR + 1);
    localparam int SUM_W = 20;

    localparam logic [1:0] REG_SHRINK = 2'd0;
    localparam logic [1:0] REG_FACTOR = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EMIT, ST_DIV, ST_SQRT, ST_SEND
    } t_state;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       kind;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end;
        logic       image_end;
        logic       run_last;
    } t_out;

    // root unit handshake
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] red_q;
        logic [SUM_W-1:0] green_q;
        logic [SUM_W-1:0] blue_q;
    } t_root_req;

    typedef struct packed {
        logic       done;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_root_rsp;
endpackage

### sv/ifpr_stream_if.sv
// valid/ready channel carrying one payload
interface ifpr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/ifpr_row_ram.sv
// row store: one write and one registered read port
module ifpr_row_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ifpr_pkg::COL_W-1:0]  i_waddr,
    input  logic [23:0]                 i_wdata,
    input  logic [ifpr_pkg::COL_W-1:0]  i_raddr,
    output logic [23:0]                 o_rdata
);
    logic [23:0] r_mem [ifpr_pkg::MAX_WIDTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### sv/ifpr_root.sv
// three-channel integer square root, one result bit per cycle
module ifpr_root (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ifpr_pkg::t_root_req  i_req,
    output ifpr_pkg::t_root_rsp  o_rsp
);
    logic [2:0]                  r_step;
    logic                        r_busy;
    logic                        r_done;
    logic [ifpr_pkg::SUM_W-1:0]  r_x   [3];
    logic [ifpr_pkg::SUM_W-1:0]  r_res [3];
    logic [ifpr_pkg::SUM_W-1:0]  n_x   [3];
    logic [ifpr_pkg::SUM_W-1:0]  n_res [3];
    logic [ifpr_pkg::SUM_W-1:0]  w_bit;

    // quotient fits 16 bits, so the root has 8 bits: bit walks 2^14 .. 2^0
    assign w_bit = ifpr_pkg::SUM_W'(1) << {r_step, 1'b0};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_x[c] >= r_res[c] + w_bit) begin
                n_x[c]   = r_x[c] - (r_res[c] + w_bit);
                n_res[c] = (r_res[c] >> 1) + w_bit;
            end else begin
                n_x[c]   = r_x[c];
                n_res[c] = r_res[c] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 3'd7;
            end else if (r_busy) begin
                r_step <= r_step - 3'd1;
                if (r_step == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x[0] <= i_req.red_q;
            r_x[1] <= i_req.green_q;
            r_x[2] <= i_req.blue_q;
            for (int c = 0; c < 3; c++) r_res[c] <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_res <= n_res;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.red   = r_res[0][7:0];
    assign o_rsp.green = r_res[1][7:0];
    assign o_rsp.blue  = r_res[2][7:0];
endmodule

### sv/integer_factor_pixel_rescaler.sv
// top level of the integer factor pixel rescaler
// usage:
//   s_in carries items: kind 0 a new pixel, kind 1 a replay pull for the
//   buffered row; m_out carries result pixels with row_end, image_end and
//   run_last flags. the config port writes registers 0..3; the user must
//   do so only when idle, the block does not enforce it; any write
//   restarts the stream position.
// enlarge: a pixel gives factor results, one per cycle while the receiver
//   takes them; a replay pull reads the row store first.
// ignored items and shrink pixels that close no group keep the state idle.
// shrink: the last pixel of a group runs the divide to a 16-bit quotient,
//   then the 8-bit root; its result is loaded into the output register in
//   the send state, which then returns to idle for the next item.
// the input is taken only in the idle state; a stalled receiver holds the
//   output register and the sequencer waits on it.
// reset clears the stream position and resets the registers; the row store
//   is not cleared, a replay only reads entries the current row wrote.
module integer_factor_pixel_rescaler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ifpr_stream_if.sink   s_in,
    ifpr_stream_if.source m_out,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [12:0]  i_cfg_data
);
    `include "integer_factor_pixel_rescaler_macros.svh"

    localparam int CW = ifpr_pkg::COL_W;
    localparam int RW = ifpr_pkg::ROW_W;
    localparam int FW = ifpr_pkg::FAC_W;
    localparam int SW = ifpr_pkg::SUM_W;

    // configuration
    logic        r_shrink;
    logic [4:0]  r_fac_raw;
    logic [12:0] r_w_raw, r_h_raw;
    logic [FW-1:0] w_f;
    logic [CW:0]   w_w;
    logic [RW:0]   w_h;

    always_comb begin
        w_f = (r_fac_raw == 5'd0) ? FW'(1)
            : (r_fac_raw > 5'(ifpr_pkg::MAX_FACTOR)) ? FW'(ifpr_pkg::MAX_FACTOR)
            : FW'(r_fac_raw);
        w_w = (r_w_raw == 13'd0) ? (CW+1)'(1)
            : (r_w_raw > 13'(ifpr_pkg::MAX_WIDTH)) ? (CW+1)'(ifpr_pkg::MAX_WIDTH)
            : (CW+1)'(r_w_raw);
        w_h = (r_h_raw == 13'd0) ? (RW+1)'(1)
            : (r_h_raw > 13'(ifpr_pkg::MAX_HEIGHT)) ? (RW+1)'(ifpr_pkg::MAX_HEIGHT)
            : (RW+1)'(r_h_raw);
    end

    // stream position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [3:0]    r_pass;
    logic [FW-1:0] r_grp;
    logic [FW-1:0] r_rsub;   // row index within a group of rows
    logic [SW-1:0] r_sum [3];

    // sequencer
    ifpr_pkg::t_state r_state, n_state;
    logic [23:0]   r_pix;
    logic [FW-1:0] r_cnt;      // copies sent
    logic          r_re_flag, r_ie_flag;
    logic [4:0]    r_dstep;
    logic          r_root_go;  // quotients are final, start the root
    logic [SW-1:0] r_rem [3];
    logic [15:0]   r_quo [3];

    ifpr_pkg::t_out r_out;
    logic           r_ovalid;

    // derived position facts
    logic w_last_col, w_last_row;
    assign w_last_col = ({1'b0, r_col} + (CW+1)'(1)) >= w_w;
    assign w_last_row = ({1'b0, r_row} + (RW+1)'(1)) >= w_h;

    // shrink kept test: output tile counts via running counters
    logic [CW:0] w_outw_full; // group start + 2f, compared with w below
    logic w_col_kept, w_row_kept, w_ocol_last, w_orow_last;
    // kept column: the whole group fits, i.e. group start + f <= w
    logic [CW+1:0] w_grp_end;
    assign w_grp_end = (CW+2)'(r_col) - (CW+2)'(r_grp) + (CW+2)'(w_f);
    assign w_col_kept = w_grp_end <= (CW+2)'(w_w);
    assign w_outw_full = (CW+1)'(w_grp_end) + (CW+1)'(w_f);
    assign w_ocol_last = (CW+2)'(w_outw_full) > (CW+2)'(w_w);
    logic [RW+1:0] w_rgrp_start;
    assign w_rgrp_start = (RW+2)'(r_row);
    assign w_row_kept = (r_rsub == '0) && (w_rgrp_start + (RW+2)'(w_f) <= (RW+2)'(w_h));
    assign w_orow_last = (w_rgrp_start + (RW+2)'(w_f) + (RW+2)'(w_f)) > (RW+2)'(w_h);

    logic w_in_fire, w_out_fire;
    assign w_in_fire  = s_in.valid && s_in.ready;
    assign w_out_fire = m_out.valid && m_out.ready;
    assign s_in.ready = (r_state == ifpr_pkg::ST_IDLE) && !i_cfg_we;

    ifpr_pkg::t_in w_in;
    assign w_in = s_in.data;

    // squares of the incoming channels
    logic [15:0] w_sq [3];
    assign w_sq[0] = {8'd0, w_in.red_in} * {8'd0, w_in.red_in};
    assign w_sq[1] = {8'd0, w_in.green_in} * {8'd0, w_in.green_in};
    assign w_sq[2] = {8'd0, w_in.blue_in} * {8'd0, w_in.blue_in};

    logic [23:0] w_ram_q;
    logic        w_ram_we;
    assign w_ram_we = w_in_fire && !r_shrink && !w_in.kind && (r_pass == 4'd0);

    ifpr_row_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_col),
        .i_wdata ({w_in.red_in, w_in.green_in, w_in.blue_in}),
        .i_raddr (r_col),
        .o_rdata (w_ram_q)
    );

    ifpr_pkg::t_root_req w_rreq;
    ifpr_pkg::t_root_rsp w_rrsp;
    assign w_rreq.start   = r_root_go;
    assign w_rreq.red_q   = SW'(r_quo[0]);
    assign w_rreq.green_q = SW'(r_quo[1]);
    assign w_rreq.blue_q  = SW'(r_quo[2]);

    ifpr_root u_root (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_rreq),
        .o_rsp  (w_rrsp)
    );

    // restoring divide step for the three sums, one quotient bit a cycle
    logic [SW-1:0] w_trial [3];
    logic [SW-1:0] w_dsh;
    assign w_dsh = SW'(w_f) << r_dstep[3:0];

    logic w_out_free, w_out_load;
    assign w_out_free = !r_ovalid || m_out.ready;
    // the output register takes a new result this cycle
    assign w_out_load = !i_cfg_we && !w_in_fire && w_out_free
        && ((r_state == ifpr_pkg::ST_EMIT) || (r_state == ifpr_pkg::ST_SEND));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ifpr_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    if (!r_shrink) begin
                        if (!w_in.kind && r_pass == 4'd0) n_state = ifpr_pkg::ST_EMIT;
                        else if (w_in.kind && r_pass != 4'd0) n_state = ifpr_pkg::ST_READ;
                    end else if (!w_in.kind && w_row_kept && w_col_kept
                                 && (r_grp + FW'(1) >= w_f)) begin
                        n_state = ifpr_pkg::ST_DIV;
                    end
                end
            end
            ifpr_pkg::ST_READ: n_state = ifpr_pkg::ST_EMIT;
            ifpr_pkg::ST_EMIT: begin
                if (w_out_free && (r_cnt + FW'(1) == w_f)) n_state = ifpr_pkg::ST_IDLE;
            end
            ifpr_pkg::ST_DIV: if (r_dstep == 5'd0) n_state = ifpr_pkg::ST_SQRT;
            ifpr_pkg::ST_SQRT: if (w_rrsp.done) n_state = ifpr_pkg::ST_SEND;
            ifpr_pkg::ST_SEND: if (w_out_free) n_state = ifpr_pkg::ST_IDLE;
            default: n_state = ifpr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) w_trial[c] = r_rem[c] - w_dsh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ifpr_pkg::ST_IDLE;
            r_shrink <= 1'b0;
            r_fac_raw <= 5'd1;
            r_w_raw  <= 13'd1;
            r_h_raw  <= 13'd1;
            r_col <= '0; r_row <= '0; r_pass <= '0; r_grp <= '0; r_rsub <= '0;
            r_ovalid <= 1'b0;
            r_cnt <= '0;
            r_dstep <= '0;
            r_root_go <= 1'b0;
            for (int c = 0; c < 3; c++) r_sum[c] <= '0;
        end else begin
            r_state <= n_state;
            r_root_go <= (r_state == ifpr_pkg::ST_DIV) && (r_dstep == 5'd0);
            if (w_out_load) r_ovalid <= 1'b1;
            else if (w_out_fire) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ifpr_pkg::REG_SHRINK: r_shrink  <= i_cfg_data[0];
                    ifpr_pkg::REG_FACTOR: r_fac_raw <= i_cfg_data[4:0];
                    ifpr_pkg::REG_WIDTH:  r_w_raw   <= i_cfg_data;
                    ifpr_pkg::REG_HEIGHT: r_h_raw   <= i_cfg_data;
                    default: ;
                endcase
                r_col <= '0; r_row <= '0; r_pass <= '0; r_grp <= '0; r_rsub <= '0;
                for (int c = 0; c < 3; c++) r_sum[c] <= '0;
            end else if (w_in_fire) begin
                r_cnt <= '0;
                r_pix <= {w_in.red_in, w_in.green_in, w_in.blue_in};
                if (!r_shrink) begin
                    if ((!w_in.kind && r_pass == 4'd0) || (w_in.kind && r_pass != 4'd0)) begin
                        r_re_flag <= w_last_col;
                        r_ie_flag <= w_last_col && w_last_row &&
                            (w_in.kind ? (r_pass == 4'd1) : (w_f == FW'(1)));
                        if (w_last_col) begin
                            r_col <= '0;
                            if (!w_in.kind && w_f > FW'(1)) begin
                                r_pass <= 4'(w_f - FW'(1));
                            end else if (w_in.kind && r_pass != 4'd1) begin
                                r_pass <= r_pass - 4'd1;
                            end else begin
                                r_pass <= '0;
                                r_row  <= w_last_row ? '0 : r_row + RW'(1);
                            end
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end else if (!w_in.kind) begin
                    // group complete: hand the sums to the divider
                    if (w_row_kept && w_col_kept && (r_grp + FW'(1) >= w_f)) begin
                        for (int c = 0; c < 3; c++) r_rem[c] <= r_sum[c] + SW'(w_sq[c]);
                        r_dstep <= 5'd15;
                        r_re_flag <= w_ocol_last;
                        r_ie_flag <= w_ocol_last && w_orow_last;
                    end
                    if (w_last_col) begin
                        r_col <= '0;
                        r_grp <= '0;
                        for (int c = 0; c < 3; c++) r_sum[c] <= '0;
                        r_row <= w_last_row ? '0 : r_row + RW'(1);
                        r_rsub <= (w_last_row || r_rsub + FW'(1) >= w_f) ? '0 : r_rsub + FW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                        if (w_row_kept && w_col_kept) begin
                            if (r_grp + FW'(1) >= w_f) begin
                                r_grp <= '0;
                                for (int c = 0; c < 3; c++) r_sum[c] <= '0;
                            end else begin
                                r_grp <= r_grp + FW'(1);
                                for (int c = 0; c < 3; c++) r_sum[c] <= r_sum[c] + SW'(w_sq[c]);
                            end
                        end
                    end
                end
            end else begin
                unique case (r_state)
                    ifpr_pkg::ST_READ: r_pix <= w_ram_q;
                    ifpr_pkg::ST_EMIT: begin
                        if (w_out_free) begin
                            r_cnt <= r_cnt + FW'(1);
                            r_out.red_out   <= r_pix[23:16];
                            r_out.green_out <= r_pix[15:8];
                            r_out.blue_out  <= r_pix[7:0];
                            r_out.run_last  <= (r_cnt + FW'(1) == w_f);
                            r_out.row_end   <= r_re_flag && (r_cnt + FW'(1) == w_f);
                            r_out.image_end <= r_ie_flag && (r_cnt + FW'(1) == w_f);
                        end
                    end
                    ifpr_pkg::ST_DIV: begin
                        for (int c = 0; c < 3; c++) begin
                            if (r_rem[c] >= w_dsh && (w_dsh >> r_dstep[3:0]) == SW'(w_f)) begin
                                r_rem[c] <= w_trial[c];
                                r_quo[c] <= {r_quo[c][14:0], 1'b1};
                            end else begin
                                r_quo[c] <= {r_quo[c][14:0], 1'b0};
                            end
                        end
                        if (r_dstep != 5'd0) r_dstep <= r_dstep - 5'd1;
                    end
                    ifpr_pkg::ST_SEND: begin
                        if (w_out_free) begin
                            r_out.red_out   <= w_rrsp.red;
                            r_out.green_out <= w_rrsp.green;
                            r_out.blue_out  <= w_rrsp.blue;
                            r_out.run_last  <= 1'b1;
                            r_out.row_end   <= r_re_flag;
                            r_out.image_end <= r_ie_flag;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // root outputs are held in the root unit until the next start
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    `IFPR_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_in.ready, r_state == ifpr_pkg::ST_IDLE)
    `IFPR_ASSERT_IMP(a_ie_has_re, i_clk, i_rst_n, m_out.valid && m_out.data.image_end, m_out.data.row_end)
    `IFPR_ASSERT_IMP(a_re_last, i_clk, i_rst_n, m_out.valid && m_out.data.row_end, m_out.data.run_last)
    `IFPR_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready, m_out.valid && $stable(m_out.data))
endmodule

### sim/integer_factor_pixel_rescaler_checker.sv
// scoreboard for the pixel rescaler: predicts result pixels and compares them
module integer_factor_pixel_rescaler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ifpr_stream_if      in_mon,
    ifpr_stream_if      out_mon,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        shrink;
    logic [4:0]  factor;
    logic [12:0] width, height;

    logic [23:0] row_store [ifpr_pkg::MAX_WIDTH];
    int unsigned col, row, replay_left, group_fill;
    int unsigned sq_sum [3];

    ifpr_pkg::t_out expected_pixels [$];

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned root_floor(int unsigned x);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r++;
        return r;
    endfunction

    task automatic restart_stream();
        col = 0;
        row = 0;
        replay_left = 0;
        group_fill = 0;
        for (int c = 0; c < 3; c++) sq_sum[c] = 0;
    endtask

    task automatic push_pixel(logic [23:0] pix, bit re, bit ie, bit last);
        ifpr_pkg::t_out o;
        o.red_out   = pix[23:16];
        o.green_out = pix[15:8];
        o.blue_out  = pix[7:0];
        o.row_end   = re;
        o.image_end = ie;
        o.run_last  = last;
        expected_pixels.push_back(o);
    endtask

    task automatic next_row(int unsigned h);
        row = (row + 1 >= h) ? 0 : row + 1;
    endtask

    task automatic predict_rescale(ifpr_pkg::t_in it);
        int unsigned f, w, h, out_w, out_h;
        bit last_col, last_row, kept, re;
        logic [23:0] pix, avg;
        int unsigned ch [3];
        f = clamp_to(32'(factor), ifpr_pkg::MAX_FACTOR);
        w = clamp_to(32'(width), ifpr_pkg::MAX_WIDTH);
        h = clamp_to(32'(height), ifpr_pkg::MAX_HEIGHT);
        pix = {it.red_in, it.green_in, it.blue_in};
        last_col = (col + 1 >= w);
        last_row = (row + 1 >= h);
        if (!shrink) begin
            if (!it.kind) begin
                // new pixels are refused while the row still owes replays
                if (replay_left != 0) return;
                row_store[ifpr_pkg::COL_W'(col)] = pix;
                for (int unsigned i = 0; i < f; i++) begin
                    re = last_col && (i + 1 == f);
                    push_pixel(pix, re, re && last_row && f == 1, i + 1 == f);
                end
                if (last_col) begin
                    col = 0;
                    if (f > 1) replay_left = f - 1;
                    else next_row(h);
                end else begin
                    col++;
                end
            end else begin
                if (replay_left == 0) return;
                pix = row_store[ifpr_pkg::COL_W'(col)];
                for (int unsigned i = 0; i < f; i++) begin
                    re = last_col && (i + 1 == f);
                    push_pixel(pix, re, re && replay_left == 1 && last_row, i + 1 == f);
                end
                if (last_col) begin
                    col = 0;
                    replay_left--;
                    if (replay_left == 0) next_row(h);
                end else begin
                    col++;
                end
            end
            return;
        end
        if (it.kind) return;
        out_w = w / f;
        out_h = h / f;
        kept = (row % f == 0) && row < out_h * f && col < out_w * f;
        if (kept) begin
            ch[0] = 32'(it.red_in);
            ch[1] = 32'(it.green_in);
            ch[2] = 32'(it.blue_in);
            for (int c = 0; c < 3; c++) sq_sum[c] += ch[c] * ch[c];
            if (group_fill + 1 >= f) begin
                for (int c = 0; c < 3; c++) avg[23-8*c -: 8] = 8'(root_floor(sq_sum[c] / f));
                re = (col / f) + 1 >= out_w;
                push_pixel(avg, re, re && (row / f) + 1 >= out_h, 1'b1);
                for (int c = 0; c < 3; c++) sq_sum[c] = 0;
                group_fill = 0;
            end else begin
                group_fill++;
            end
        end
        if (last_col) begin
            col = 0;
            group_fill = 0;
            for (int c = 0; c < 3; c++) sq_sum[c] = 0;
            next_row(h);
        end else begin
            col++;
        end
    endtask

    function automatic int field_diff(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v == act_v) return 0;
        $error("%s expected %0d actual %0d", name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        ifpr_pkg::t_out e, a;
        if (!i_rst_n) begin
            shrink = 1'b0;
            factor = 5'd1;
            width  = 13'd1;
            height = 13'd1;
            restart_stream();
            expected_pixels.delete();
            o_fail_count   = 0;
            o_result_count = 0;
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                a = out_mon.data;
                o_result_count++;
                if (expected_pixels.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_count++;
                end else begin
                    e = expected_pixels.pop_front();
                    o_fail_count += field_diff("red_out", 32'(e.red_out), 32'(a.red_out))
                                  + field_diff("green_out", 32'(e.green_out), 32'(a.green_out))
                                  + field_diff("blue_out", 32'(e.blue_out), 32'(a.blue_out))
                                  + field_diff("row_end", 32'(e.row_end), 32'(a.row_end))
                                  + field_diff("image_end", 32'(e.image_end),
                                               32'(a.image_end))
                                  + field_diff("run_last", 32'(e.run_last), 32'(a.run_last));
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ifpr_pkg::REG_SHRINK: shrink = i_cfg_data[0];
                    ifpr_pkg::REG_FACTOR: factor = i_cfg_data[4:0];
                    ifpr_pkg::REG_WIDTH:  width  = i_cfg_data;
                    ifpr_pkg::REG_HEIGHT: height = i_cfg_data;
                endcase
                restart_stream();
            end
            if (in_mon.valid && in_mon.ready) predict_rescale(in_mon.data);
        end
        o_pending = expected_pixels.size();
    end
endmodule

### sim/integer_factor_pixel_rescaler_test.sv
// top of the pixel rescaler testbench: clock, reset, stimulus and verdict
module integer_factor_pixel_rescaler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 195;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = ifpr_pkg::REG_SHRINK;
    logic [12:0] cfg_data = '0;

    ifpr_stream_if #(.T(ifpr_pkg::t_in))  in_ch ();
    ifpr_stream_if #(.T(ifpr_pkg::t_out)) out_ch ();

    int fail_count, pending, result_count;
    int item_count = 0;
    int cycles = 0;
    int image_count = 0;
    bit quiet = 1'b0;      // last part of the run: no idling on either side
    bit hold_start = 1'b0; // asks the receiver for one long hold-off

    always #1 i_clk = ~i_clk;

    integer_factor_pixel_rescaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (in_ch),
        .m_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    integer_factor_pixel_rescaler_checker scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left, hold_left;
        bit hold_seen;
        stall_left = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_start && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (quiet) begin
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // starts and ends at a falling edge; valid is left high for the next item
    task automatic send_item(bit kind, logic [23:0] pix);
        ifpr_pkg::t_in it;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        it.kind     = kind;
        it.red_in   = pix[23:16];
        it.green_in = pix[15:8];
        it.blue_in  = pix[7:0];
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        item_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [23:0] any_pixel();
        return 24'($urandom_range(0, 24'hFFFFFF));
    endfunction

    // let the pipeline drain before touching registers
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_mode(bit shr, int f, int w, int h);
        wait_idle();
        write_reg(ifpr_pkg::REG_SHRINK, 13'(shr));
        write_reg(ifpr_pkg::REG_FACTOR, 13'(f));
        write_reg(ifpr_pkg::REG_WIDTH, 13'(w));
        write_reg(ifpr_pkg::REG_HEIGHT, 13'(h));
    endtask

    // one well formed image with random content and a little noise
    task automatic send_image(bit shr, int f, int w, int h);
        int fe;
        fe = (f < 1) ? 1 : (f > ifpr_pkg::MAX_FACTOR ? ifpr_pkg::MAX_FACTOR : f);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(0, 11) == 0) send_item(1'($urandom_range(0, 1)), any_pixel());
                send_item(1'b0, any_pixel());
            end
            if (!shr)
                for (int p = 0; p < (fe - 1) * w; p++) send_item(1'b1, any_pixel());
        end
        image_count++;
    endtask

    initial begin
        int f, w, h;
        bit shr;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // pull with nothing owed, straight after reset
        send_item(1'b1, 24'h000000);
        // enlarge by 3 over a 2x2 image, extreme channel values
        set_mode(1'b0, 3, 2, 2);
        send_item(1'b0, 24'hFFFFFF);
        send_item(1'b0, 24'h000000);
        send_item(1'b0, 24'h123456);   // refused: the row still owes replays
        repeat (4) send_item(1'b1, 24'hFFFFFF);
        send_item(1'b0, 24'hFF00FF);
        send_item(1'b0, 24'h00FF00);
        repeat (4) send_item(1'b1, 24'h000000);
        send_item(1'b1, 24'h000000);   // pull with nothing owed
        // factor 0 acts as 1, zero width and height act as 1
        set_mode(1'b0, 0, 0, 0);
        send_item(1'b0, 24'hA5A5A5);
        send_item(1'b0, 24'h5A5A5A);
        // shrink by 2 on 5x3: leftover column and row, pulls ignored
        set_mode(1'b1, 2, 5, 3);
        send_image(1'b1, 2, 5, 3);
        send_item(1'b1, 24'hFFFFFF);
        // row narrower than the factor
        set_mode(1'b1, 2, 1, 2);
        send_item(1'b0, 24'hFFFFFF);
        send_item(1'b0, 24'hFFFFFF);
        // factor above the maximum, widest group of all-ones
        set_mode(1'b1, 31, 16, 16);
        repeat (16) send_item(1'b0, 24'hFFFFFF);
        // saturating width and height, a partial row only
        set_mode(1'b0, 16, 8191, 8191);
        repeat (2) send_item(1'b0, any_pixel());

        // random images; one long receiver hold-off while items keep coming
        while (item_count < ITEM_TARGET) begin
            shr = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) f = shr ? 5 : $urandom_range(16, 31);
            else f = $urandom_range(0, 4);
            w = $urandom_range(1, (f > 4) ? 2 : 6);
            h = $urandom_range(1, (f > 4) ? 1 : 4);
            if (shr) begin
                w = w + f;
                h = h + f;
            end
            set_mode(shr, f, w, h);
            if (item_count > 90 && !hold_start) hold_start = 1'b1;
            if (item_count > ITEM_TARGET * 4 / 5) quiet = 1'b1;
            send_image(shr, f, w, h);
        end

        wait_idle();
        $display("%0d items over %0d random images, %0d result pixels checked",
                 item_count, image_count, result_count);
        $display("covered enlarge and shrink, factor, width and height extremes");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/ifpr_pkg.sv
sv/ifpr_stream_if.sv
sv/ifpr_row_ram.sv
sv/ifpr_root.sv
sv/integer_factor_pixel_rescaler.sv
sim/integer_factor_pixel_rescaler_checker.sv
sim/integer_factor_pixel_rescaler_test.sv
